// ----- hw/rtl/pmst_pkg.sv -----
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared constants and types for the spanning tree block.
// ----------------------------------------------------------------------------
package pmst_pkg;

  localparam int MaxVerticesDef = 32;
  localparam int WeightBitsDef  = 16;
  localparam int VtxW           = 5;
  localparam int CntW           = 6;
  localparam int WgtFieldW      = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  // one beat of the result channel
  typedef struct packed {
    logic             last_edge;
    logic             reached;
    logic [WgtFieldW-1:0] tree_weight;
    logic [VtxW-1:0]  parent_vertex;
    logic [VtxW-1:0]  tree_vertex;
  } result_t;

endpackage

// ----- hw/rtl/pmst_adj_mem.sv -----
// ----------------------------------------------------------------------------
// pmst_adj_mem
// Adjacency entry store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmst_adj_mem
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int DATA_W       = WeightBitsDef + 1,
  localparam int AW = 2 * $clog2(MAX_VERTICES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [2**AW];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ----- hw/rtl/prim_minimum_spanning_tree.sv -----
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim spanning tree over a stored adjacency matrix.
// ----------------------------------------------------------------------------
// Input beats carry a command in in_tuser: clear the store, add an entry (the
// smaller weight is kept on a repeated pair) or run. An add reads the old
// entry in the accept cycle and writes in the next one. Each memory entry
// holds a present bit beside its weight; a clear walks every entry, one a
// cycle, and in_tready stays low while it walks. The same clearing pass runs
// after reset. A run seeds the keys, then for each joined vertex scans the
// keys for the minimum and relaxes its row through the one read port, and
// ends with a final scan. It then sends n-1 result beats, vertex 1 to n-1,
// one a cycle while out_tready is high, with out_tlast on the final one.
// in_tready is low while a command is at work; a stalled output holds its
// beat and the sequencer waits. cfg_we writes vertex_count; the user is to
// do so only while idle, as the block does not enforce it. Reset sets
// vertex_count to 32.
module prim_minimum_spanning_tree
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int WEIGHT_BITS  = WeightBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [CntW-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // from_vertex[4:0], to_vertex[9:5], edge_weight[25:10]
  input  logic [31:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tree_vertex[4:0], parent_vertex[9:5], tree_weight[25:10]
  output logic [31:0] out_tdata,
  // reached[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VB;
  localparam int NV = 2 ** VB;
  localparam int KW = WEIGHT_BITS + 1;
  localparam int LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int NW = VB + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ADD, S_INIT, S_SCAN, S_RELAX, S_EMIT
  } state_t;

  state_t              state_r;
  logic [CntW-1:0]     vcount_r;
  logic [AW-1:0]       clr_r;
  logic [KW-1:0]       key_r [NV];
  logic [VB-1:0]       parent_r [NV];
  logic [NV-1:0]       intree_r;
  logic [NW-1:0]       n_r, idx_r;
  logic [VB-1:0]       from_r, to_r, u_r, best_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                found_r;
  logic [KW-1:0]       best_key_r;
  logic [VB-1:0]       rv_r;        // vertex whose entry of u's row is on rd_data
  logic                rv_ok_r;
  logic                outv_r;
  result_t             res_r;

  logic [1:0]          cmd;
  logic [4:0]          fv, tv;
  logic [WEIGHT_BITS-1:0] wv;
  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [KW-1:0]       wr_data, rd_data;
  logic [NW-1:0]       n_act;
  logic [VB-1:0]       idx_v;

  assign cmd = in_tuser;
  assign fv  = in_tdata[4:0];
  assign tv  = in_tdata[9:5];
  assign wv  = WEIGHT_BITS'(in_tdata[25:10]);
  assign idx_v = idx_r[VB-1:0];

  // active vertex count with saturation, zero taken as one
  always_comb begin
    if (vcount_r == '0) n_act = NW'(1);
    else if (32'(vcount_r) > LIM) n_act = NW'(LIM);
    else n_act = NW'(vcount_r);
  end

  // memory addressing, entry is {present, weight}
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {from_r, to_r};
    wr_data = {1'b1, w_r};
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r == S_ADD) begin
      wr_en = !rd_data[WEIGHT_BITS] || (w_r < rd_data[WEIGHT_BITS-1:0]);
    end
    if (state_r == S_IDLE) rd_addr = {VB'(fv), VB'(tv)};
    else rd_addr = {u_r, idx_v};
  end

  pmst_adj_mem #(.MAX_VERTICES(NV), .DATA_W(KW)) u_mem (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      vcount_r <= CntW'(32);
      intree_r <= '0;
      outv_r   <= 1'b0;
    end else begin
      if (cfg_we) vcount_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            from_r <= VB'(fv);
            to_r   <= VB'(tv);
            w_r    <= wv;
            n_r    <= n_act;
            idx_r  <= '0;
            if (cmd == CMD_CLEAR) begin
              clr_r   <= '0;
              state_r <= S_CLEAR;
            end else if (cmd == CMD_ADD) begin
              if (32'(fv) < MAX_VERTICES && 32'(tv) < MAX_VERTICES) state_r <= S_ADD;
            end else if (cmd == CMD_RUN) begin
              state_r <= S_INIT;
            end
          end
        end
        S_CLEAR: begin
          // one entry a cycle
          clr_r <= clr_r + AW'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_ADD: begin
          state_r <= S_IDLE;
        end
        S_INIT: begin
          // seed keys, one vertex a cycle
          key_r[idx_v]    <= (idx_r == '0) ? '0 : {1'b1, {WEIGHT_BITS{1'b0}}};
          parent_r[idx_v] <= '0;
          intree_r[idx_v] <= 1'b0;
          if (idx_r == n_r - NW'(1)) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else idx_r <= idx_r + NW'(1);
        end
        S_SCAN: begin
          // minimum (key, index) over unjoined reached vertices
          if (!intree_r[idx_v] && !key_r[idx_v][WEIGHT_BITS] &&
              (!found_r || key_r[idx_v] < best_key_r)) begin
            found_r    <= 1'b1;
            best_r     <= idx_v;
            best_key_r <= key_r[idx_v];
          end
          if (idx_r == n_r - NW'(1)) begin
            idx_r <= '0;
            if (found_r || (!intree_r[idx_v] && !key_r[idx_v][WEIGHT_BITS])) begin
              if (!intree_r[idx_v] && !key_r[idx_v][WEIGHT_BITS] &&
                  (!found_r || key_r[idx_v] < best_key_r)) begin
                u_r <= idx_v;
                intree_r[idx_v] <= 1'b1;
              end else begin
                u_r <= best_r;
                intree_r[best_r] <= 1'b1;
              end
              rv_ok_r <= 1'b0;
              state_r <= S_RELAX;
            end else begin
              idx_r   <= NW'(1);
              state_r <= (n_r == NW'(1)) ? S_IDLE : S_EMIT;
            end
          end else idx_r <= idx_r + NW'(1);
        end
        S_RELAX: begin
          // read row of u one entry a cycle, relax the previous entry
          rv_r    <= idx_v;
          rv_ok_r <= (idx_r < n_r);
          if (rv_ok_r && rd_data[WEIGHT_BITS] && !intree_r[rv_r] &&
              key_r[rv_r] > {1'b0, rd_data[WEIGHT_BITS-1:0]}) begin
            key_r[rv_r]    <= {1'b0, rd_data[WEIGHT_BITS-1:0]};
            parent_r[rv_r] <= u_r;
          end
          if (idx_r == n_r) begin
            if (!rv_ok_r) begin
              idx_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end else idx_r <= idx_r + NW'(1);
        end
        S_EMIT: begin
          // one result beat per vertex after vertex 0
          if (!outv_r || out_tready) begin
            outv_r <= 1'b1;
            res_r.tree_vertex   <= 5'(idx_v);
            res_r.reached       <= intree_r[idx_v];
            res_r.parent_vertex <= intree_r[idx_v] ? 5'(parent_r[idx_v]) : '0;
            res_r.tree_weight   <= intree_r[idx_v] ?
                                   WgtFieldW'(key_r[idx_v][WEIGHT_BITS-1:0]) : '0;
            res_r.last_edge     <= (idx_r == n_r - NW'(1));
            if (idx_r == n_r - NW'(1)) state_r <= S_IDLE;
            else idx_r <= idx_r + NW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (outv_r && out_tready && state_r != S_EMIT) outv_r <= 1'b0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign out_tlast  = res_r.last_edge;
  assign out_tuser  = res_r.reached;
  assign out_tdata  = {6'd0, res_r.tree_weight, res_r.parent_vertex, res_r.tree_vertex};

endmodule
